// ----- rtl/tfs_pkg.sv -----
// shared types and constants for the timed frame sequencer
package tfs_pkg;

  typedef enum logic [2:0] {
    OP_QUERY = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_PAUSE = 3'd3,
    OP_WRITE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    RUN_STOPPED = 2'd0,
    RUN_PAUSED  = 2'd1,
    RUN_RUNNING = 2'd2
  } run_e;

  typedef enum logic [1:0] {
    MODE_ONESHOT = 2'd0,
    MODE_SHUTTLE = 2'd1,
    MODE_SWING   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CFG_PLAY_MODE   = 2'd0,
    CFG_LOOP_LENGTH = 2'd1,
    CFG_FIRST_FRAME = 2'd2,
    CFG_LAST_FRAME  = 2'd3
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MOD,
    ST_WALK,
    ST_OUT
  } state_e;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned TimeW   = 40;
  localparam logic [23:0] DurReset = 24'd256;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] frame_time;
    logic [4:0]  entry_index;
    logic [23:0] duration;
  } in_item_t;

  typedef struct packed {
    logic [4:0] frame_index;
    logic [1:0] run_state;
    logic       just_finished;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic mod_step;
    logic walk_step;
  } dp_cmd_t;

  typedef struct packed {
    logic running;
    logic oneshot_end;
    logic need_mod;
    logic mod_done;
    logic walk_done;
  } dp_sts_t;

endpackage

// ----- rtl/tfs_ctrl.sv -----
// controller state machine for the timed frame sequencer
module tfs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  tfs_pkg::dp_sts_t    sts_i,
  output tfs_pkg::dp_cmd_t    cmd_o
);
  tfs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tfs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tfs_pkg::ST_IDLE: begin
        if (in_valid) state_d = tfs_pkg::ST_PREP;
      end
      tfs_pkg::ST_PREP: begin
        if (!sts_i.running || sts_i.oneshot_end) state_d = tfs_pkg::ST_OUT;
        else if (sts_i.need_mod) state_d = tfs_pkg::ST_MOD;
        else state_d = tfs_pkg::ST_WALK;
      end
      tfs_pkg::ST_MOD: begin
        if (sts_i.mod_done) state_d = tfs_pkg::ST_WALK;
      end
      tfs_pkg::ST_WALK: begin
        if (sts_i.walk_done) state_d = tfs_pkg::ST_OUT;
      end
      tfs_pkg::ST_OUT: begin
        if (!out_stall) state_d = tfs_pkg::ST_IDLE;
      end
      default: state_d = tfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_q)
      tfs_pkg::ST_IDLE: begin
        in_stall     = 1'b0;
        cmd_o.load   = in_valid;
      end
      tfs_pkg::ST_PREP: begin
        cmd_o.prep     = 1'b1;
      end
      tfs_pkg::ST_MOD:  cmd_o.mod_step = 1'b1;
      tfs_pkg::ST_WALK: cmd_o.walk_step = 1'b1;
      tfs_pkg::ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

// ----- rtl/tfs_dp.sv -----
// datapath: run state, duration table, restoring modulo and frame walk
module tfs_dp #(
  parameter int unsigned FRAME_COUNT = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfs_pkg::in_item_t   in_item_i,
  input  logic                cfg_we_i,
  input  logic [tfs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  tfs_pkg::dp_cmd_t    cmd_i,
  output tfs_pkg::dp_sts_t    sts_o,
  output tfs_pkg::out_item_t  out_item_o
);
  localparam int unsigned TW = tfs_pkg::TimeW;

  logic [1:0]  mode_q;
  logic [23:0] len_q;
  logic [4:0]  first_q, last_q;
  logic [1:0]  run_q;
  logic [31:0] stamp_q;
  logic [4:0]  cur_q;
  logic        done_q;
  logic [31:0] valid_q;
  logic [23:0] mem_q [32];
  tfs_pkg::in_item_t item_q;

  logic [TW:0]  t_q;       // dividend during the modulo, then walk time
  logic [25:0]  r_q;       // partial remainder
  logic [5:0]   sh_q;
  logic [5:0]   k_q;       // walk index, one past upper bound possible
  logic [24:0]  dlen;
  logic [23:0]  rd_q;
  logic         rd_vld_q;
  logic         rd_in_q;
  logic [5:0]   k_nx;
  logic [25:0]  dlen_w, rem_sh, rem_nx, mod_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= tfs_pkg::MODE_SHUTTLE;
      len_q   <= 24'd256;
      first_q <= '0;
      last_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tfs_pkg::CFG_PLAY_MODE:   mode_q  <= cfg_data_i[1:0];
        tfs_pkg::CFG_LOOP_LENGTH: len_q   <= cfg_data_i[23:0];
        tfs_pkg::CFG_FIRST_FRAME: first_q <= cfg_data_i[4:0];
        tfs_pkg::CFG_LAST_FRAME:  last_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign dlen = (mode_q == tfs_pkg::MODE_SWING) ? {len_q, 1'b0} : {1'b0, len_q};

  logic [31:0] elapsed;
  assign elapsed = (item_q.frame_time >= stamp_q) ? item_q.frame_time - stamp_q : '0;

  logic [23:0] rd_dur;
  assign rd_dur = !rd_in_q ? '0 : (rd_vld_q ? rd_q : tfs_pkg::DurReset);

  logic [TW:0] t_sub;
  assign t_sub = t_q - {{(TW-23){1'b0}}, rd_dur};

  logic walk_stop;
  assign walk_stop = (t_q == '0) || t_q[TW] || (k_q > {1'b0, last_q});

  logic [5:0] k_sel;
  assign k_sel = (k_q < {1'b0, first_q} + 6'd1) ? {1'b0, first_q} : k_q - 6'd1;

  // one modulo step: shift in the next dividend bit, subtract when it fits; mod_res folds swing results
  assign dlen_w  = {1'b0, dlen};
  assign rem_sh  = {r_q[24:0], t_q[TW-1]};
  assign rem_nx  = (rem_sh >= dlen_w) ? rem_sh - dlen_w : rem_sh;
  assign mod_res = (len_q == '0) ? '0 :
                   ((mode_q == tfs_pkg::MODE_SWING) && (rem_nx >= {2'b0, len_q})) ?
                   dlen_w - rem_nx : rem_nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= tfs_pkg::RUN_STOPPED;
      stamp_q <= '0;
      cur_q   <= '0;
      done_q  <= 1'b0;
      valid_q <= '0;
    end else begin
      if (cmd_i.load) begin
        done_q <= 1'b0;
        unique case (in_item_i.operation)
          tfs_pkg::OP_START: begin
            run_q   <= tfs_pkg::RUN_RUNNING;
            stamp_q <= in_item_i.frame_time;
          end
          tfs_pkg::OP_STOP:  run_q <= tfs_pkg::RUN_STOPPED;
          tfs_pkg::OP_PAUSE: run_q <= tfs_pkg::RUN_PAUSED;
          tfs_pkg::OP_WRITE: begin
            if (32'(in_item_i.entry_index) < FRAME_COUNT)
              valid_q[in_item_i.entry_index] <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd_i.prep && sts_o.running && sts_o.oneshot_end) begin
        run_q  <= tfs_pkg::RUN_STOPPED;
        cur_q  <= last_q;
        done_q <= 1'b1;
      end
      if (cmd_i.walk_step && walk_stop) begin
        if (k_sel > {1'b0, last_q}) cur_q <= last_q;
        else cur_q <= k_sel[4:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
      if (in_item_i.operation == tfs_pkg::OP_WRITE &&
          32'(in_item_i.entry_index) < FRAME_COUNT)
        mem_q[in_item_i.entry_index] <= in_item_i.duration;
    end
  end

  // registered table read, one entry ahead of the walk
  assign k_nx = cmd_i.prep ? {1'b0, first_q} : k_q + 6'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep || (cmd_i.walk_step && !walk_stop)) begin
      rd_q     <= mem_q[k_nx[4:0]];
      rd_vld_q <= valid_q[k_nx[4:0]];
      rd_in_q  <= !k_nx[5] && (32'(k_nx) < FRAME_COUNT);
    end
  end

  // prep load, restoring modulo with one dividend bit per cycle, and walk subtraction
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      t_q  <= {1'b0, elapsed, 8'd0};
      r_q  <= '0;
      sh_q <= 6'(TW - 1);
      k_q  <= {1'b0, first_q};
    end else if (cmd_i.mod_step) begin
      r_q  <= rem_nx;
      sh_q <= sh_q - 6'd1;
      if (sh_q == 6'd0) t_q <= {{(TW-25){1'b0}}, mod_res};
      else t_q <= {t_q[TW-1:0], 1'b0};
    end else if (cmd_i.walk_step && !walk_stop) begin
      t_q <= t_sub;
      k_q <= k_q + 6'd1;
    end
  end

  assign sts_o.running     = (run_q == tfs_pkg::RUN_RUNNING);
  assign sts_o.oneshot_end = (mode_q == tfs_pkg::MODE_ONESHOT) &&
                             ({elapsed, 8'd0} >= {16'd0, len_q});
  assign sts_o.need_mod    = (mode_q == tfs_pkg::MODE_SHUTTLE) ||
                             (mode_q == tfs_pkg::MODE_SWING);
  assign sts_o.mod_done    = (sh_q == 6'd0);
  assign sts_o.walk_done   = walk_stop;

  assign out_item_o.frame_index   = cur_q;
  assign out_item_o.run_state     = run_q;
  assign out_item_o.just_finished = done_q;
endmodule

// ----- rtl/timed_frame_sequencer_unit.sv -----
// top level of the timed frame sequencer
// usage:
//   in channel: in_valid / in_stall with an in_item_t payload; an item is taken
//   when valid is high and stall low. out channel likewise, out_stall driven by
//   the receiver. each item gives exactly one result item.
//   config: cfg_valid / cfg_ready with index and data; write only while idle.
// timing:
//   one item at a time. prep, then a 40 step restoring modulo in shuttle
//   and swing modes, then a walk of one duration per cycle.
//   the result is offered straight after prep when stopped, paused or at a
//   one-shot end, after the walk in a running one-shot or unreduced mode,
//   and after modulo and walk in shuttle or swing.
//   the next item can be taken in the cycle after the result leaves.
// reset:
//   asynchronous active low. mode shuttle, loop length 1.0, range 0..0,
//   stopped, every duration 1.0 via per entry valid bits, no sweep needed.
// stall:
//   a stalled result holds; no new item is taken until it is delivered.
module timed_frame_sequencer_unit #(
  parameter int unsigned FRAME_COUNT = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  tfs_pkg::in_item_t  in_item_i,
  output logic               out_valid,
  input  logic               out_stall,
  output tfs_pkg::out_item_t out_item_o,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [tfs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  tfs_pkg::dp_cmd_t cmd;
  tfs_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  tfs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts_i(sts), .cmd_o(cmd)
  );

  tfs_dp #(.FRAME_COUNT(FRAME_COUNT)) u_dp (
    .clk_i, .rst_ni,
    .in_item_i, .cfg_we_i(cfg_valid & cfg_ready), .cfg_idx_i(cfg_index_i),
    .cfg_data_i, .cmd_i(cmd), .sts_o(sts), .out_item_o
  );
endmodule

// ----- rtl/tfs_checker.sv -----
// port level checker for the timed frame sequencer
module tfs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input tfs_pkg::out_item_t out_item_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(out_item_o)) else $error("out hold");
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall) else $error("busy accept");
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_stall |=> !out_valid) else $error("early out");
  a_finish_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_item_o.just_finished |-> out_item_o.run_state == tfs_pkg::RUN_STOPPED)
    else $error("finish state");
endmodule

bind timed_frame_sequencer_unit tfs_checker u_chk (.*);
